// ----- hdl/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg: shared codes for the deadline timer queue
// Request operation codes and result kind codes used on the stream ports.
// ----------------------------------------------------------------------------
package dtq_pkg;

    // Operation selector carried in the slave-side tuser.
    typedef logic [1:0] op_t;

    // Result kind carried in the master-side tuser.
    typedef logic [1:0] kind_t;

    localparam op_t OP_SCHED_REL = 2'd0;
    localparam op_t OP_SCHED_ABS = 2'd1;
    localparam op_t OP_TICK      = 2'd2;

    localparam kind_t KIND_ACCEPT   = 2'd0;
    localparam kind_t KIND_FULL     = 2'd1;
    localparam kind_t KIND_BAD_TIME = 2'd2;
    localparam kind_t KIND_DISPATCH = 2'd3;

endpackage

// ----- hdl/dtq_ram.sv -----
// ----------------------------------------------------------------------------
// dtq_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/deadline_timer_queue_unit.sv -----
// A schedule request answers after its free-slot search; a bad time answers without one.
// A tick runs one scan pass per dispatched entry plus a final pass; output stalls hold it.
// Each scan pass reads the slot memory once per slot and compares in one shared unit.
// Throughput: one request at a time; the input is ready only while the sequencer idles.
// Reset: rst_n clears the time counter, the slot valid bits and all control state.
// Slot contents are not cleared; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit: table of timed entries ordered by deadline
// Accepts relative and absolute schedule requests and time ticks. A tick
// dispatches every due entry earliest first, lowest slot on ties, and
// re-arms periodic entries.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int TIME_WIDTH = 32,
    parameter int ID_WIDTH   = 8,
    localparam int IN_W  = ((ID_WIDTH + TIME_WIDTH + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((ID_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // Fields from bit 0 up: task_id, time_value, periodic.
    input  logic [IN_W-1:0]    s_axis_tdata,
    // Fields from bit 0 up: op.
    input  dtq_pkg::op_t       s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // Fields from bit 0 up: task_out, now_time.
    output logic [OUT_W-1:0]   m_axis_tdata,
    // Fields from bit 0 up: kind.
    output dtq_pkg::kind_t     m_axis_tuser,
    output logic               m_axis_tlast
);

    import dtq_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int ENTRY_W = 2 * TIME_WIDTH + ID_WIDTH + 1;
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [TIME_WIDTH-1:0] TSIGN    = {1'b1, {(TIME_WIDTH-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_RESP = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DISP = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [TIME_WIDTH-1:0] dl_reg, dl_next;
    logic [TIME_WIDTH-1:0] per_reg, per_next;
    logic                  rep_reg, rep_next;
    kind_t                 kind_reg, kind_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]      p_idx_reg, p_idx_next;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic [DEPTH-1:0]      done_reg, done_next;
    logic                  best_found_reg, best_found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [TIME_WIDTH-1:0] best_key_reg, best_key_next;
    logic [ID_WIDTH-1:0]   best_handle_reg, best_handle_next;
    logic [TIME_WIDTH-1:0] best_period_reg, best_period_next;
    logic                  best_repeat_reg, best_repeat_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [ID_WIDTH-1:0]   pend_handle_reg, pend_handle_next;
    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [ID_WIDTH-1:0]   out_task_reg, out_task_next;
    logic [TIME_WIDTH-1:0] out_now_reg, out_now_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_fire;
    op_t                   in_op;
    logic [ID_WIDTH-1:0]   in_id;
    logic [TIME_WIDTH-1:0] in_tv;
    logic                  in_per;
    logic                  out_free;

    logic [TIME_WIDTH-1:0] add_a, add_b, add_sum;
    logic                  add_c;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

    logic [TIME_WIDTH-1:0] rd_dl, rd_period, diff, key;
    logic [ID_WIDTH-1:0]   rd_handle;
    logic                  rd_repeat, due, take;

    // Request unpacking.
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_op   = s_axis_tuser;
    assign in_id   = s_axis_tdata[ID_WIDTH-1:0];
    assign in_tv   = s_axis_tdata[ID_WIDTH +: TIME_WIDTH];
    assign in_per  = s_axis_tdata[ID_WIDTH + TIME_WIDTH];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Output stream from the result register.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[ID_WIDTH-1:0] = out_task_reg;
        m_axis_tdata[ID_WIDTH +: TIME_WIDTH] = out_now_reg;
    end

    // Slot memory: deadline, handle, period and repeat flag per slot.
    dtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_dl     = ram_rdata[TIME_WIDTH-1:0];
    assign rd_handle = ram_rdata[TIME_WIDTH +: ID_WIDTH];
    assign rd_period = ram_rdata[TIME_WIDTH + ID_WIDTH +: TIME_WIDTH];
    assign rd_repeat = ram_rdata[ENTRY_W-1];

    // Shared adder for deadlines, time checks and the time counter.
    assign add_sum = add_a + add_b + {{(TIME_WIDTH-1){1'b0}}, add_c};

    // Due check and ordering key of the slot read in the previous cycle.
    assign diff = rd_dl - now_reg;
    assign due  = (diff == '0) || diff[TIME_WIDTH-1];
    assign key  = diff ^ TSIGN;
    assign take = p_vld_reg && valid_reg[p_idx_reg] && !done_reg[p_idx_reg] && due
                  && (!best_found_reg || (key < best_key_reg));

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        now_next         = now_reg;
        id_next          = id_reg;
        dl_next          = dl_reg;
        per_next         = per_reg;
        rep_next         = rep_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        issue_done_next  = issue_done_reg;
        p_vld_next       = 1'b0;
        p_idx_next       = p_idx_reg;
        valid_next       = valid_reg;
        done_next        = done_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_key_next    = best_key_reg;
        best_handle_next = best_handle_reg;
        best_period_next = best_period_reg;
        best_repeat_next = best_repeat_reg;
        pend_vld_next    = pend_vld_reg;
        pend_handle_next = pend_handle_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_kind_next    = out_kind_reg;
        out_task_next    = out_task_reg;
        out_now_next     = out_now_reg;
        out_last_next    = out_last_reg;
        add_a            = now_reg;
        add_b            = '0;
        add_c            = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = {rep_reg, per_reg, id_reg, dl_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    id_next = in_id;
                    case (in_op)
                        OP_SCHED_REL:
                        begin
                            add_a    = now_reg;
                            add_b    = in_tv;
                            dl_next  = add_sum;
                            per_next = in_tv;
                            rep_next = in_per;
                            idx_next = '0;
                            if (in_tv[TIME_WIDTH-1] || (in_per && (in_tv == '0)))
                            begin
                                kind_next  = KIND_BAD_TIME;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        OP_SCHED_ABS:
                        begin
                            // Deadline minus present time must be positive.
                            add_a    = in_tv;
                            add_b    = ~now_reg;
                            add_c    = 1'b1;
                            dl_next  = in_tv;
                            per_next = '0;
                            rep_next = 1'b0;
                            idx_next = '0;
                            if ((add_sum == '0) || add_sum[TIME_WIDTH-1])
                            begin
                                kind_next  = KIND_BAD_TIME;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        OP_TICK:
                        begin
                            add_a           = now_reg;
                            add_c           = 1'b1;
                            now_next        = add_sum;
                            done_next       = '0;
                            best_found_next = 1'b0;
                            pend_vld_next   = 1'b0;
                            idx_next        = '0;
                            issue_done_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FREE:
            begin
                // Look for the lowest free slot, one slot a cycle.
                if (!valid_reg[idx_reg])
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = idx_reg;
                    valid_next[idx_reg] = 1'b1;
                    kind_next           = KIND_ACCEPT;
                    state_next          = S_RESP;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    kind_next  = KIND_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_task_next  = id_reg;
                    out_now_next   = now_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // Issue reads in order; compare each slot in the cycle after its read.
                if (!issue_done_reg)
                begin
                    p_vld_next = 1'b1;
                    p_idx_next = idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                        idx_next        = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (take)
                begin
                    best_found_next  = 1'b1;
                    best_idx_next    = p_idx_reg;
                    best_key_next    = key;
                    best_handle_next = rd_handle;
                    best_period_next = rd_period;
                    best_repeat_next = rd_repeat;
                end
                if (issue_done_reg && p_vld_reg && (p_idx_reg == LAST_IDX))
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                if (best_found_reg)
                begin
                    // The previous dispatch is not the last one; send it now.
                    if (!pend_vld_reg || out_free)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_DISPATCH;
                            out_task_next  = pend_handle_reg;
                            out_now_next   = now_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_vld_next           = 1'b1;
                        pend_handle_next        = best_handle_reg;
                        done_next[best_idx_reg] = 1'b1;
                        if (best_repeat_reg)
                        begin
                            add_a     = now_reg;
                            add_b     = best_period_reg;
                            ram_we    = 1'b1;
                            ram_waddr = best_idx_reg;
                            ram_wdata = {1'b1, best_period_reg, best_handle_reg, add_sum};
                        end
                        else
                        begin
                            valid_next[best_idx_reg] = 1'b0;
                        end
                        best_found_next = 1'b0;
                        idx_next        = '0;
                        issue_done_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
                else if (pend_vld_reg)
                begin
                    // Nothing more is due: the held dispatch closes the tick.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_DISPATCH;
                        out_task_next  = pend_handle_reg;
                        out_now_next   = now_reg;
                        out_last_next  = 1'b1;
                        pend_vld_next  = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            valid_reg      <= '0;
            done_reg       <= '0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            p_vld_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            p_vld_reg      <= p_vld_next;
            best_found_reg <= best_found_next;
            pend_vld_reg   <= pend_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        dl_reg          <= dl_next;
        per_reg         <= per_next;
        rep_reg         <= rep_next;
        kind_reg        <= kind_next;
        p_idx_reg       <= p_idx_next;
        best_idx_reg    <= best_idx_next;
        best_key_reg    <= best_key_next;
        best_handle_reg <= best_handle_next;
        best_period_reg <= best_period_next;
        best_repeat_reg <= best_repeat_next;
        pend_handle_reg <= pend_handle_next;
        out_kind_reg    <= out_kind_next;
        out_task_reg    <= out_task_next;
        out_now_reg     <= out_now_next;
        out_last_reg    <= out_last_next;
    end

    // A schedule answer is always the only and final result of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_DISPATCH)) |-> m_axis_tlast)
        else $error("schedule answer without last flag");

    // The time counter moves only when a tick request is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && (in_op == OP_TICK)) |=> $stable(now_reg))
        else $error("time counter changed without a tick");

    // The chosen entry always refers to an occupied slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        best_found_reg |-> valid_reg[best_idx_reg])
        else $error("selected slot is not valid");

    // A held dispatch never survives past the end of a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> ((state_reg == S_SCAN) || (state_reg == S_DISP)))
        else $error("dispatch left pending outside a tick");

endmodule
